@@ hdl/ntr_pkg.sv @@
// Package for the tanh neuron with L1 relevance.
// Holds the datapath opcodes, the command and status structs and fixed widths.
// Used by ntr_div, ntr_datapath, ntr_ctrl and neuron_tanh_with_relevance.
package ntr_pkg;

	localparam int ACC_W    = 48;
	localparam int REL_W    = 26;
	localparam int DIV_DW   = 49;
	localparam int DIV_VW   = 35;
	localparam int DIV_CW   = 6;
	localparam int K_W      = 5;
	localparam int TAYLOR_TERMS = 16;
	localparam int SQUARINGS    = 4;
	localparam logic [REL_W-1:0] THRESH_RESET = 26'd328;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_BIAS,
		OP_PREP,
		OP_TMUL,
		OP_TDIV,
		OP_TACC,
		OP_SMUL,
		OP_SRND,
		OP_FDIV,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t            op;
		logic [K_W-1:0] k;
		logic           acc_en;
	} cmd_t;

	typedef struct packed {
		logic big;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

@@ hdl/ntr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Used for the final tanh quotient, whose divisor is a signal; uses ntr_pkg.
module ntr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ntr_pkg::DIV_DW-1:0] dividend,
	input  logic [ntr_pkg::DIV_VW-1:0] divisor,
	output logic [ntr_pkg::DIV_DW-1:0] quotient,
	output logic                       done
);
	import ntr_pkg::*;

	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_VW:0]   rem_sh;
	logic [DIV_VW:0]   diff;

	assign rem_sh = {rem_q, quo_q[DIV_DW-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so the top bit of rem_sh is spare.
			if (!diff[DIV_VW]) begin
				rem_q <= diff[DIV_VW-1:0];
				quo_q <= {quo_q[DIV_DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIV_VW-1:0];
				quo_q <= {quo_q[DIV_DW-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ hdl/ntr_datapath.sv @@
// Datapath: accumulators, shared multiplier, divider, tanh evaluation and result registers.
// Driven by ntr_ctrl through cmd_t; uses ntr_pkg and ntr_div.
module ntr_datapath #(
	parameter int MAX_INPUTS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ntr_pkg::cmd_t             cmd,
	output ntr_pkg::stat_t            stat,
	input  logic                      cfg_we,
	input  logic [ntr_pkg::REL_W-1:0] cfg_wdata,
	input  logic signed [15:0]        weight,
	input  logic signed [15:0]        activation,
	input  logic signed [15:0]        bias,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [15:0]        node_output,
	output logic [ntr_pkg::REL_W-1:0] relevance,
	output logic                      keep_node
);
	import ntr_pkg::*;

	localparam longint CAP_FULL = longint'(MAX_INPUTS) * 32768;
	localparam longint CAP_SAT  = (CAP_FULL > 67108863) ? 67108863 : CAP_FULL;
	localparam logic [REL_W-1:0] REL_CAP = REL_W'(CAP_SAT);
	localparam logic signed [ACC_W:0] ACC_HI = {2'b00, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W:0] ACC_LO = {2'b11, {(ACC_W-1){1'b0}}};
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	logic signed [ACC_W-1:0] acc_q;
	logic [REL_W-1:0]        mag_q;
	logic [REL_W-1:0]        thr_q;
	logic signed [15:0]      bias_q;
	logic                    neg_q;
	logic                    big_q;
	logic [31:0]             z_q;
	logic [32:0]             term_q;
	logic [32:0]             sum_q;
	logic [65:0]             prod_s1;
	logic                    out_valid_q;
	logic signed [15:0]      node_q;
	logic [REL_W-1:0]        rel_q;
	logic                    keep_q;

	logic signed [31:0]      wa;
	logic signed [ACC_W:0]   acc_add;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [ACC_W:0]   bias_add;
	logic signed [ACC_W-1:0] bias_sat;
	logic [16:0]             abs_w;
	logic [REL_W:0]          mag_add;
	logic [ACC_W-1:0]        t_abs;
	logic [31:0]             sq_in;
	logic [64:0]             rnd_sum;
	logic [33:0]             den;
	logic [32:0]             num;
	logic [32:0]             recip_k;
	logic [2:0]              recip_sh;
	logic [65:0]             tquo;
	logic [32:0]             mul_a;
	logic [32:0]             mul_b;
	logic                    div_start;
	logic [DIV_DW-1:0]       div_dividend;
	logic [DIV_VW-1:0]       div_divisor;
	logic [DIV_DW-1:0]       div_quo;
	logic                    div_done;
	logic [15:0]             r_mag;

	assign wa      = weight * activation;
	assign acc_add = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(wa);
	always_comb begin
		if (acc_add > ACC_HI) begin
			acc_next = ACC_HI[ACC_W-1:0];
		end else if (acc_add < ACC_LO) begin
			acc_next = ACC_LO[ACC_W-1:0];
		end else begin
			acc_next = acc_add[ACC_W-1:0];
		end
	end

	assign bias_add = {acc_q[ACC_W-1], acc_q} + ((ACC_W+1)'(bias_q) <<< 15);
	always_comb begin
		if (bias_add > ACC_HI) begin
			bias_sat = ACC_HI[ACC_W-1:0];
		end else if (bias_add < ACC_LO) begin
			bias_sat = ACC_LO[ACC_W-1:0];
		end else begin
			bias_sat = bias_add[ACC_W-1:0];
		end
	end

	assign abs_w   = weight[15] ? 17'(-{weight[15], weight}) : {1'b0, weight};
	assign mag_add = {1'b0, mag_q} + (REL_W+1)'(abs_w);
	assign t_abs   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
	assign sq_in   = sum_q[32] ? 32'hFFFF_FFFF : sum_q[31:0];
	assign rnd_sum = {1'b0, prod_s1[63:0]} + 65'h0_8000_0000;
	assign num     = ONE_Q32 - sum_q;
	assign den     = {1'b0, ONE_Q32} + {1'b0, sum_q};
	assign r_mag   = big_q ? 16'd32767 : div_quo[15:0];

	// Division of a Taylor term by its index k: the term is below 2^32, so multiplying by
	// floor(2^(32+l)/k) + 1 with l = ceil(log2(k)) and shifting right by 32+l gives the exact floor.
	always_comb begin
		case (cmd.k)
			5'd1:    begin recip_k = 33'h1_0000_0001; recip_sh = 3'd0; end
			5'd2:    begin recip_k = 33'h1_0000_0001; recip_sh = 3'd1; end
			5'd3:    begin recip_k = 33'h1_5555_5556; recip_sh = 3'd2; end
			5'd4:    begin recip_k = 33'h1_0000_0001; recip_sh = 3'd2; end
			5'd5:    begin recip_k = 33'h1_9999_999A; recip_sh = 3'd3; end
			5'd6:    begin recip_k = 33'h1_5555_5556; recip_sh = 3'd3; end
			5'd7:    begin recip_k = 33'h1_2492_4925; recip_sh = 3'd3; end
			5'd8:    begin recip_k = 33'h1_0000_0001; recip_sh = 3'd3; end
			5'd9:    begin recip_k = 33'h1_C71C_71C8; recip_sh = 3'd4; end
			5'd10:   begin recip_k = 33'h1_9999_999A; recip_sh = 3'd4; end
			5'd11:   begin recip_k = 33'h1_745D_1746; recip_sh = 3'd4; end
			5'd12:   begin recip_k = 33'h1_5555_5556; recip_sh = 3'd4; end
			5'd13:   begin recip_k = 33'h1_3B13_B13C; recip_sh = 3'd4; end
			5'd14:   begin recip_k = 33'h1_2492_4925; recip_sh = 3'd4; end
			5'd15:   begin recip_k = 33'h1_1111_1112; recip_sh = 3'd4; end
			5'd16:   begin recip_k = 33'h1_0000_0001; recip_sh = 3'd4; end
			default: begin recip_k = 33'h1_0000_0001; recip_sh = 3'd0; end
		endcase
	end

	assign tquo = prod_s1 >> (7'd32 + 7'(recip_sh));

	always_comb begin
		mul_a = term_q;
		mul_b = {1'b0, z_q};
		case (cmd.op)
			OP_TDIV: begin
				mul_a = {1'b0, prod_s1[63:32]};
				mul_b = recip_k;
			end
			OP_SMUL: begin
				mul_a = {1'b0, sq_in};
				mul_b = {1'b0, sq_in};
			end
			default: begin
				mul_a = term_q;
				mul_b = {1'b0, z_q};
			end
		endcase
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (cmd.op)
			OP_FDIV: begin
				div_start    = 1'b1;
				div_dividend = DIV_DW'({num, 16'b0}) - DIV_DW'({num, 1'b0}) + DIV_DW'(den);
				div_divisor  = {den, 1'b0};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	ntr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			mag_q       <= '0;
			thr_q       <= THRESH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.acc_en) begin
				acc_q <= acc_next;
				mag_q <= (mag_add > {1'b0, REL_CAP}) ? REL_CAP : mag_add[REL_W-1:0];
			end
			case (cmd.op)
				OP_BIAS: begin
					acc_q <= bias_sat;
				end
				OP_OUT: begin
					acc_q <= '0;
					mag_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			bias_q <= bias;
		end
		case (cmd.op)
			OP_PREP: begin
				neg_q  <= acc_q[ACC_W-1];
				big_q  <= t_abs >= (ACC_W'(6) << 30);
				z_q    <= t_abs[32:1];
				term_q <= ONE_Q32;
				sum_q  <= ONE_Q32;
			end
			OP_TMUL, OP_TDIV, OP_SMUL: begin
				prod_s1 <= 66'(mul_a) * 66'(mul_b);
			end
			OP_TACC: begin
				term_q <= tquo[32:0];
				if (cmd.k[0]) begin
					sum_q <= sum_q - tquo[32:0];
				end else begin
					sum_q <= sum_q + tquo[32:0];
				end
			end
			OP_SRND: begin
				sum_q <= rnd_sum[64:32];
			end
			OP_OUT: begin
				node_q <= neg_q ? -$signed(r_mag) : $signed(r_mag);
				rel_q  <= mag_q;
				keep_q <= mag_q >= thr_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.big      = big_q;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign node_output = node_q;
	assign relevance   = rel_q;
	assign keep_node   = keep_q;

endmodule

@@ hdl/ntr_ctrl.sv @@
// Controller: sequences accumulation, bias, Taylor series, squarings and final quotient.
// Issues cmd_t to ntr_datapath and reads stat_t back; uses ntr_pkg.
module ntr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_element,
	output logic           in_ready,
	input  ntr_pkg::stat_t stat,
	output ntr_pkg::cmd_t  cmd
);
	import ntr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_BIAS, S_PREP, S_CHK, S_TMUL, S_TDIV, S_TACC,
		S_SMUL, S_SRND, S_FDIV, S_FWAIT, S_OUT
	} state_t;

	state_t         state_q;
	logic [K_W-1:0] k_q;
	logic [1:0]     sq_q;
	logic           accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			sq_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE:  if (accept && last_element) state_q <= S_BIAS;
				S_BIAS:  state_q <= S_PREP;
				S_PREP:  state_q <= S_CHK;
				S_CHK: begin
					k_q     <= K_W'(1);
					state_q <= stat.big ? S_OUT : S_TMUL;
				end
				S_TMUL:  state_q <= S_TDIV;
				S_TDIV:  state_q <= S_TACC;
				S_TACC: begin
					if (k_q == K_W'(TAYLOR_TERMS)) begin
						sq_q    <= '0;
						state_q <= S_SMUL;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_TMUL;
					end
				end
				S_SMUL:  state_q <= S_SRND;
				S_SRND: begin
					if (sq_q == 2'(SQUARINGS - 1)) begin
						state_q <= S_FDIV;
					end else begin
						sq_q    <= sq_q + 1'b1;
						state_q <= S_SMUL;
					end
				end
				S_FDIV:  state_q <= S_FWAIT;
				S_FWAIT: if (stat.div_done) state_q <= S_OUT;
				S_OUT:   if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.acc_en = accept;
		cmd.k      = k_q;
		case (state_q)
			S_BIAS:  cmd.op = OP_BIAS;
			S_PREP:  cmd.op = OP_PREP;
			S_TMUL:  cmd.op = OP_TMUL;
			S_TDIV:  cmd.op = OP_TDIV;
			S_TACC:  cmd.op = OP_TACC;
			S_SMUL:  cmd.op = OP_SMUL;
			S_SRND:  cmd.op = OP_SRND;
			S_FDIV:  cmd.op = OP_FDIV;
			S_OUT:   cmd.op = stat.out_free ? OP_OUT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

@@ hdl/neuron_tanh_with_relevance.sv @@
// Top level of the dense-layer neuron with tanh output and L1 relevance.
// Instantiates ntr_ctrl and ntr_datapath; uses ntr_pkg.
//
//   Channel  Signals                                   Direction
//   in       in_valid/in_ready, weight, activation,    into block
//            bias, last_element
//   out      out_valid/out_ready, node_output,         out of block
//            relevance, keep_node
//   cfg      cfg_we, cfg_wdata (prune threshold)       into block
//
// An item that is not the last of its row is accumulated as it is accepted; the next can follow at once.
// The last item of a row starts the tanh evaluation: 16 Taylor terms, each a multiply, a
// reciprocal multiply for the division by k and an accumulate, 4 squarings, each a multiply
// and a rounding, and a 49-step bit-serial division, while in_ready stays low; arguments
// of magnitude 6 or more skip the evaluation and go straight to the output.
// A result that waits in the output register holds the controller before the next result.
// Reset clears both sums and loads the threshold with 328.
module neuron_tanh_with_relevance #(
	parameter int MAX_INPUTS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [15:0]        weight,
	input  logic signed [15:0]        activation,
	input  logic signed [15:0]        bias,
	input  logic                      last_element,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [15:0]        node_output,
	output logic [ntr_pkg::REL_W-1:0] relevance,
	output logic                      keep_node,
	input  logic                      cfg_we,
	input  logic [ntr_pkg::REL_W-1:0] cfg_wdata
);
	import ntr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ntr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.last_element (last_element),
		.in_ready     (in_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	ntr_datapath #(
		.MAX_INPUTS (MAX_INPUTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.weight      (weight),
		.activation  (activation),
		.bias        (bias),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.node_output (node_output),
		.relevance   (relevance),
		.keep_node   (keep_node)
	);

	// The last item of a row closes the input until its result is produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_element) |=> !in_ready)
		else $error("input still open after the last item of a row");

	// A new result is only produced while the input is closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result produced while input was open");

endmodule

@@ verif/neuron_tanh_with_relevance_test.sv @@
// Self-checking testbench for neuron_tanh_with_relevance: random bursts of rows in,
// results compared against an in-bench fixed-point tanh and relevance predictor.
// Depends on ntr_pkg and the neuron_tanh_with_relevance RTL only.
module neuron_tanh_with_relevance_test;
	import ntr_pkg::*;

	localparam int MAX_INPUTS = 1024;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 1200;
	localparam int LONG_HOLD = 1500;
	localparam logic signed [63:0] ACC_HI = 64'sd140737488355327;
	localparam logic signed [63:0] ACC_LO = -64'sd140737488355328;
	localparam logic [63:0] ONE_Q32 = 64'd1 << 32;

	typedef struct {
		logic signed [15:0] w;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               last;
	} item_t;

	typedef struct {
		logic signed [15:0] node;
		logic [REL_W-1:0]   rel;
		logic               keep;
	} node_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] weight = 0;
	logic signed [15:0] activation = 0;
	logic signed [15:0] bias = 0;
	logic last_element = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] node_output;
	logic [REL_W-1:0] relevance;
	logic keep_node;
	logic cfg_we = 0;
	logic [REL_W-1:0] cfg_wdata = 0;

	item_t pending_items[$];
	node_result_t expected_nodes[$];

	logic signed [63:0] dot_sum = 0;
	logic [63:0] weight_mag_sum = 0;
	logic [REL_W-1:0] threshold = THRESH_RESET;

	int mismatches = 0;
	int idle_cycles = 0;
	logic in_took = 0;
	logic hold_start = 0;
	logic hold_seen = 0;
	int hold_left = 0;
	int burst_left = 8;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_count = 0;

	neuron_tanh_with_relevance #(.MAX_INPUTS(MAX_INPUTS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.weight(weight), .activation(activation), .bias(bias),
		.last_element(last_element),
		.out_valid(out_valid), .out_ready(out_ready),
		.node_output(node_output), .relevance(relevance), .keep_node(keep_node),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic logic signed [63:0] acc_add(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [63:0] s;
		s = x + y;
		if (s > ACC_HI) return ACC_HI;
		if (s < ACC_LO) return ACC_LO;
		return s;
	endfunction

	// exp(-2t) in Q0.32 via exp(-t/8) Taylor series, then four squarings.
	function automatic logic [15:0] tanh_q15(input logic signed [63:0] x);
		logic [63:0] t, z, s, term, num, den, r;
		t = (x < 0) ? 64'(-x) : 64'(x);
		if (t >= (64'd6 << 30)) begin
			r = 32767;
		end else begin
			z = t >> 1;
			s = ONE_Q32;
			term = ONE_Q32;
			for (int k = 1; k <= TAYLOR_TERMS; k++) begin
				term = (term * z) >> 32;
				term = term / k;
				if (k % 2) s = s - term;
				else s = s + term;
			end
			for (int i = 0; i < SQUARINGS; i++) begin
				if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
				s = (s * s + (64'd1 << 31)) >> 32;
			end
			num = ONE_Q32 - s;
			den = ONE_Q32 + s;
			r = (2 * 32767 * num + den) / (2 * den);
		end
		return (x < 0) ? 16'(-r) : 16'(r);
	endfunction

	task automatic accept_item(input item_t it);
		logic [63:0] mag;
		logic [63:0] rel_cap;
		logic signed [63:0] total;
		node_result_t res;
		rel_cap = (MAX_INPUTS * 64'd32768 > 64'h3FF_FFFF) ? 64'h3FF_FFFF
			: MAX_INPUTS * 64'd32768;
		dot_sum = acc_add(dot_sum, 64'(it.w) * 64'(it.a));
		mag = weight_mag_sum + ((it.w < 0) ? 64'(-64'(it.w)) : 64'(it.w));
		weight_mag_sum = (mag > rel_cap) ? rel_cap : mag;
		if (it.last) begin
			total = acc_add(dot_sum, 64'(it.b) * 64'sd32768);
			res.node = tanh_q15(total);
			res.rel = weight_mag_sum[REL_W-1:0];
			res.keep = (weight_mag_sum >= 64'(threshold));
			expected_nodes.push_back(res);
			dot_sum = 0;
			weight_mag_sum = 0;
		end
	endtask

	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			accept_item('{weight, activation, bias, last_element});
		if (arst_n && out_valid && out_ready) begin
			if (expected_nodes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: node %0d rel %0d keep %0d",
						node_output, relevance, keep_node);
			end else begin
				node_result_t e;
				e = expected_nodes.pop_front();
				if (e.node !== node_output || e.rel !== relevance || e.keep !== keep_node) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: node %0d/%0d rel %0d/%0d keep %0d/%0d (exp/act)",
							e.node, node_output, e.rel, relevance, e.keep, keep_node);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		item_t it;
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				weight <= it.w;
				activation <= it.a;
				bias <= it.b;
				last_element <= it.last;
				in_valid <= 1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Receiver: alternates between always ready and random stalls, and once holds off
	// for a long stretch that it counts itself.
	always @(negedge clk) begin
		stall_count++;
		if (stall_count >= 300) begin
			stall_count = 0;
			stall_mode = $urandom_range(0, 2);
		end
		if (hold_start && !hold_seen) begin
			hold_seen = 1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end
		else if (stall_mode == 0) out_ready <= 1;
		else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
		else out_ready <= ($urandom_range(0, 4) == 0);
	end

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_row(input int len, input int big);
		item_t it;
		for (int i = 0; i < len; i++) begin
			if (big) begin
				it.w = ($urandom_range(0, 1)) ? 16'sh8000 : 16'sh7FFF;
				it.a = ($urandom_range(0, 1)) ? 16'sh8000 : 16'sh7FFF;
			end else begin
				it.w = pick_value();
				it.a = pick_value();
			end
			it.b = pick_value();
			it.last = (i == len - 1);
			pending_items.push_back(it);
		end
	endtask

	task automatic add_long_row(input int len, input logic signed [15:0] w,
			input logic signed [15:0] a);
		for (int i = 0; i < len; i++)
			pending_items.push_back('{w, a, 16'sh0, i == len - 1});
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !in_valid && expected_nodes.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [REL_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		threshold = v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic add_random_rows(input int n_items);
		int made;
		int len;
		made = 0;
		while (made < n_items) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
			add_row(len, $urandom_range(0, 7) == 0);
			made += len;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed rows under the reset threshold.
		pending_items.push_back('{16'sh0, 16'sh0, 16'sh0, 1'b1});
		pending_items.push_back('{16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1});
		pending_items.push_back('{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1});
		pending_items.push_back('{16'sh0148, 16'sh0100, 16'sh0, 1'b1});
		pending_items.push_back('{16'sh0147, 16'shFF00, 16'sh0, 1'b1});
		pending_items.push_back('{16'sh0001, 16'sh0001, 16'shFFFF, 1'b1});
		pending_items.push_back('{16'sh4000, 16'sh7FFF, 16'sh1234, 1'b0});
		pending_items.push_back('{16'shC000, 16'sh7FFF, 16'sh0001, 1'b1});
		add_long_row(6, 16'sh8000, 16'sh8000);
		add_long_row(6, 16'sh8000, 16'sh7FFF);
		add_long_row(5, 16'sh7FFF, 16'sh7FFF);
		drain();

		// The relevance sum saturates at its cap, which equals the threshold.
		write_threshold(26'd33554432);
		add_long_row(MAX_INPUTS + 5, 16'sh8000, 16'sh0100);
		add_random_rows(40);
		drain();

		write_threshold('0);
		hold_start = 1;
		add_random_rows(80);
		drain();

		write_threshold(26'h3FF_FFFF);
		add_random_rows(40);
		drain();

		write_threshold(26'($urandom_range(0, 300000)));
		add_random_rows(60);
		drain();

		if (mismatches == 0 && expected_nodes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
